[rtl/swm_pkg.sv]
// ---------------------------------------------------------------------------
// Sliding window maximum package
// Shared constants for the sliding window maximum unit and its channels.
// ---------------------------------------------------------------------------
package swm_pkg;

  // Default depth of the window and default sample width.
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // The window size register is a fixed seven-bit field.
  localparam int CFG_BITS = 7;

  // Window size after reset.
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

endpackage

[rtl/swm_in_if.sv]
// ---------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel that moves one sample word with its restart flag.
// ---------------------------------------------------------------------------
interface swm_in_if
  import swm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

[rtl/swm_out_if.sv]
// ---------------------------------------------------------------------------
// Result output channel
// Valid/ready channel that moves one window maximum word.
// ---------------------------------------------------------------------------
interface swm_out_if
  import swm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

[rtl/swm_cfg_if.sv]
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes the window size register.
// ---------------------------------------------------------------------------
interface swm_cfg_if
  import swm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

[rtl/swm_cell.sv]
// ---------------------------------------------------------------------------
// Running maximum cell
// Holds the maximum of the samples of ages zero up to its own place in the
// chain. On each accepted word it takes its neighbor's old maximum, which
// covers one age less, and folds in the new sample.
// ---------------------------------------------------------------------------
module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] prev_max,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] max_nxt,
  output logic signed [SAMPLE_BITS-1:0] max_r
);

  // Fold the new sample into the neighbor's maximum.
  assign max_nxt = (sample >= prev_max) ? sample : prev_max;

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (en) begin
      max_r <= max_nxt;
    end
  end

endmodule

[rtl/sliding_window_maximum_unit.sv]
// ---------------------------------------------------------------------------
// Sliding window maximum unit
// A result word is registered as its sample is accepted and is valid in the next cycle.
// Throughput: one sample per cycle while the output register is empty or being read.
// The rate is set by the chain of running maximum cells, one compare each.
// Reset (rst_n low, synchronous) clears the fill and live counts and output
// valid and sets the window size to three; cell contents need no reset.
// ---------------------------------------------------------------------------
module sliding_window_maximum_unit
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  swm_in_if.sink     in_ch,
  swm_out_if.source  out_ch,
  swm_cfg_if.sink    cfg_ch
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CMP_W = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

  logic [CFG_BITS-1:0]           window_size_r;
  logic [CNT_W-1:0]              fill_r;
  logic [CNT_W-1:0]              fill_nxt;
  logic [CNT_W-1:0]              live_r;
  logic [CNT_W-1:0]              live_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] window_max_r;
  logic signed [SAMPLE_BITS-1:0] window_max_nxt;
  logic [CMP_W-1:0]              ws_ext;
  logic [CMP_W-1:0]              w_eff;
  logic [IDX_W-1:0]              sel_idx;
  logic                          in_fire;
  logic                          emit;
  logic signed [SAMPLE_BITS-1:0] cell_q [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cell_d [MAX_WINDOW];

  // Handshakes: the output register parts the two sides.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.window_max = window_max_r;

  // Window size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      window_size_r <= cfg_ch.window_size;
    end
  end

  // Effective window: zero acts as one, sizes beyond the chain are clamped.
  always_comb begin
    ws_ext = CMP_W'(window_size_r);
    if (ws_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (ws_ext > CMP_W'(MAX_WINDOW)) begin
      w_eff = CMP_W'(MAX_WINDOW);
    end else begin
      w_eff = ws_ext;
    end
  end

  // Number of youngest samples still inside the window. It grows by one per
  // word and is capped by the current window, so a window that widens mid
  // stream refills from the present instead of reaching back to samples that
  // have already expired.
  always_comb begin
    if (in_ch.restart) begin
      live_nxt = CNT_W'(1);
    end else if (CMP_W'(live_r) >= w_eff) begin
      live_nxt = CNT_W'(w_eff);
    end else begin
      live_nxt = live_r + CNT_W'(1);
    end
    sel_idx = IDX_W'(live_nxt - CNT_W'(1));
  end

  // Chain of running maximum cells; the first cell sees only the new sample.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] prev_max;
    if (i == 0) begin : g_head
      assign prev_max = in_ch.sample;
    end else begin : g_link
      assign prev_max = cell_q[i-1];
    end
    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .en       (in_fire),
      .prev_max (prev_max),
      .sample   (in_ch.sample),
      .max_nxt  (cell_d[i]),
      .max_r    (cell_q[i])
    );
  end

  // Fill count, restarted by the restart flag and saturating at the depth.
  always_comb begin
    if (in_ch.restart) begin
      fill_nxt = CNT_W'(1);
    end else if (fill_r < CNT_W'(MAX_WINDOW)) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else begin
      fill_nxt = fill_r;
    end
  end

  // A result is due once the window is full; it is the cell at the oldest
  // sample that is still live.
  assign emit           = CMP_W'(fill_nxt) >= w_eff;
  assign window_max_nxt = cell_d[sel_idx];

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        fill_r <= fill_nxt;
        live_r <= live_nxt;
      end
    end
  end

  // Output data register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      window_max_r <= window_max_nxt;
    end
  end

  // The fill count never passes the chain depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_WINDOW))
    else $error("fill count beyond window depth");

  // A restart with a window wider than one yields no result for that word.
  a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.restart && (w_eff != CMP_W'(1)) |=> !out_valid_r)
    else $error("result emitted on restart before window filled");

  // With a window of one, the result is the sample itself.
  a_unit_window: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (w_eff == CMP_W'(1)) |=>
      out_valid_r && (window_max_r == $past(in_ch.sample)))
    else $error("unit window result differs from sample");

  // Nothing is emitted in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule
